@@ rtl/core/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the work-stealing deque.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

  localparam int WORD_W = 64;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    ACT_PUSH     = 2'd0,
    ACT_POPBOT   = 2'd1,
    ACT_POPTOP   = 2'd2,
    ACT_SETDEPTH = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTEMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_FAIL = 2'd1,
    SEL_SLOT = 2'd2
  } data_sel_t;

endpackage

`default_nettype wire

@@ rtl/core/wsd_ifs.sv @@
// ----------------------------------------------------------------------------
// wsd_ifs
// Valid/ready channel interfaces for deque action and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsd_in_if import wsd_pkg::*; ();
  logic    valid;
  logic    ready;
  action_t action;
  word_t   element;
  word_t   depth_value;

  modport source (output valid, action, element, depth_value, input ready);
  modport sink   (input valid, action, element, depth_value, output ready);
endinterface

interface wsd_out_if import wsd_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  word_t   data;

  modport source (output valid, status, data, input ready);
  modport sink   (input valid, status, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/work_stealing_deque.sv @@
// Result path: stage one registers, then the output register; a stall holds both.
// Throughput: one action per cycle while the result side keeps up; the one
// slot RAM access per action bounds it.
// Reset: counters, fail word and pipeline valids clear; slot contents stay
// undefined until pushed. No clearing pass.
// ----------------------------------------------------------------------------
// work_stealing_deque
// Bounded work-stealing deque: push/pop at the bottom, steal at the top,
// ring of DEPTH slots addressed by wrap pointers kept beside the counters.
// ----------------------------------------------------------------------------
`default_nettype none

module work_stealing_deque import wsd_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wsd_in_if.sink     in_ch,
  wsd_out_if.source  out_ch,
  input  wire logic  cfg_we,
  input  wire word_t cfg_wdata
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [AW-1:0] SLOT_CNT  = AW'(DEPTH);
  // slot of the all-ones counter; the slot index restarts at zero on wrap
  localparam logic [AW-1:0] WRAP_INC  = AW'({WORD_W{1'b1}} % WORD_W'(DEPTH));
  localparam logic [AW-1:0] WRAP_DEC  =
    AW'(WORD_W'(DEPTH) - ({WORD_W{1'b1}} % WORD_W'(DEPTH)));

  typedef logic [AW-1:0] slot_t;

  word_t     top_r, top_nxt, bot_r, bot_nxt;
  slot_t     top_slot_r, top_slot_nxt, bot_slot_r, bot_slot_nxt;
  word_t     fail_word_r;
  logic      s1_valid_r;
  status_t   s1_status_r, s1_status_nxt;
  data_sel_t s1_sel_r, s1_sel_nxt;
  logic      out_valid_r;
  status_t   out_status_r;
  word_t     out_data_r;

  word_t     size;
  logic      accept, s1_move;
  logic      ram_we, ram_re;
  slot_t     ram_waddr, ram_raddr;
  word_t     ram_rdata;

  function automatic slot_t slot_sub(slot_t p, slot_t k);
    return (p >= k) ? p - k : p - k + SLOT_CNT;
  endfunction

  function automatic slot_t slot_inc(slot_t p, word_t c);
    if (c == '1) begin
      return slot_sub(p, WRAP_INC);
    end
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  function automatic slot_t slot_dec(slot_t p, word_t c);
    if (c == '0) begin
      return slot_sub(p, WRAP_DEC);
    end
    return (p == '0) ? LAST_SLOT : p - 1'b1;
  endfunction

  assign s1_move     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_move;
  assign accept      = in_ch.valid && in_ch.ready;
  assign size        = bot_r - top_r;

  always_comb begin
    top_nxt       = top_r;
    bot_nxt       = bot_r;
    top_slot_nxt  = top_slot_r;
    bot_slot_nxt  = bot_slot_r;
    s1_status_nxt = ST_OK;
    s1_sel_nxt    = SEL_ZERO;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = bot_slot_r;
    ram_raddr     = top_slot_r;
    if (accept) begin
      unique case (in_ch.action)
        ACT_PUSH: begin
          if (size >= WORD_W'(DEPTH)) begin
            s1_status_nxt = ST_FULL;
          end else begin
            ram_we       = 1'b1;
            bot_nxt      = bot_r + 1'b1;
            bot_slot_nxt = slot_inc(bot_slot_r, bot_r);
          end
        end
        ACT_POPBOT: begin
          if (size == '0) begin
            s1_status_nxt = ST_EMPTY;
            s1_sel_nxt    = SEL_FAIL;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = slot_dec(bot_slot_r, bot_r);
            s1_sel_nxt = SEL_SLOT;
            if (size == WORD_W'(1)) begin
              top_nxt      = top_r + 1'b1;
              top_slot_nxt = slot_inc(top_slot_r, top_r);
            end else begin
              bot_nxt      = bot_r - 1'b1;
              bot_slot_nxt = slot_dec(bot_slot_r, bot_r);
            end
          end
        end
        ACT_POPTOP: begin
          if (size == '0) begin
            s1_status_nxt = ST_EMPTY;
            s1_sel_nxt    = SEL_FAIL;
          end else begin
            ram_re       = 1'b1;
            s1_sel_nxt   = SEL_SLOT;
            top_nxt      = top_r + 1'b1;
            top_slot_nxt = slot_inc(top_slot_r, top_r);
          end
        end
        ACT_SETDEPTH: begin
          // empty deque: slot pointers already coincide, only counters move
          if (top_r != bot_r) begin
            s1_status_nxt = ST_NOTEMPTY;
          end else begin
            top_nxt = in_ch.depth_value;
            bot_nxt = in_ch.depth_value;
          end
        end
        default: begin
          s1_status_nxt = ST_OK;
        end
      endcase
    end
  end

  wsd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.element),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      bot_r       <= '0;
      top_slot_r  <= '0;
      bot_slot_r  <= '0;
      fail_word_r <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      top_r      <= top_nxt;
      bot_r      <= bot_nxt;
      top_slot_r <= top_slot_nxt;
      bot_slot_r <= bot_slot_nxt;
      if (cfg_we) begin
        fail_word_r <= cfg_wdata;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_valid_r && s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= s1_status_nxt;
      s1_sel_r    <= s1_sel_nxt;
    end
    if (s1_valid_r && s1_move) begin
      out_status_r <= s1_status_r;
      unique case (s1_sel_r)
        SEL_FAIL: out_data_r <= fail_word_r;
        SEL_SLOT: out_data_r <= ram_rdata;
        default:  out_data_r <= '0;
      endcase
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.data   = out_data_r;

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (bot_r - top_r) <= WORD_W'(DEPTH))
    else $error("deque occupancy above capacity");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (top_r == bot_r) |-> (top_slot_r == bot_slot_r))
    else $error("slot pointers split on empty deque");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_move) |-> !in_ch.ready)
    else $error("action taken while stage one is stalled");

  a_read_feeds: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> (s1_valid_r && s1_sel_r == SEL_SLOT))
    else $error("slot read without a pending pop");

endmodule

`default_nettype wire

@@ rtl/core/wsd_ram.sv @@
// ----------------------------------------------------------------------------
// wsd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ verif/tb_work_stealing_deque.sv @@
// ----------------------------------------------------------------------------
// tb_work_stealing_deque
// Self-checking bench for the work-stealing deque. A driver feeds action beats
// from a queue with random gaps, a monitor checks each result beat against a
// cycle-free deque predictor, and the fail word is rewritten between phases
// while the block is idle.
// ----------------------------------------------------------------------------
module tb_work_stealing_deque import wsd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 8;
  localparam int PHASES      = 5;
  localparam int PHASE_BEATS = 250;

  typedef struct packed {
    action_t act;
    word_t   element;
    word_t   depth_value;
  } action_beat_t;

  typedef struct packed {
    status_t status;
    word_t   data;
  } deque_result_t;

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  cfg_we    = 1'b0;
  word_t cfg_wdata = '0;

  wsd_in_if  in_if ();
  wsd_out_if out_if ();

  work_stealing_deque #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  word_t top_ctr  = '0;
  word_t bot_ctr  = '0;
  word_t fail_val = '0;
  word_t slot_mem [DEPTH];

  deque_result_t result_due_q [$];
  action_beat_t  pending_q [$];

  int unsigned issued_cnt = 0;
  int unsigned taken_cnt  = 0;
  int unsigned gen_cnt    = 0;
  int unsigned err_cnt    = 0;
  int unsigned res_cnt    = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned act_cnt [4] = '{default: 0};
  int unsigned full_cnt   = 0;
  int unsigned empty_cnt  = 0;
  int unsigned reject_cnt = 0;
  int unsigned cfg_cnt    = 0;
  int unsigned in_gap     = 0;
  int unsigned out_stall  = 0;
  bit          steady     = 1'b0;

  function automatic int slot_of(input word_t ctr);
    return int'(ctr % word_t'(DEPTH));
  endfunction

  function automatic void deque_step(input action_beat_t b);
    word_t         occ;
    deque_result_t r;
    occ      = bot_ctr - top_ctr;
    r.status = ST_OK;
    r.data   = '0;
    act_cnt[b.act]++;
    case (b.act)
      ACT_PUSH: begin
        if (occ >= word_t'(DEPTH)) begin
          r.status = ST_FULL;
          full_cnt++;
        end else begin
          slot_mem[slot_of(bot_ctr)] = b.element;
          bot_ctr = bot_ctr + 1;
        end
      end
      ACT_POPBOT: begin
        if (occ == 0) begin
          r.status = ST_EMPTY;
          r.data   = fail_val;
          empty_cnt++;
        end else begin
          r.data = slot_mem[slot_of(bot_ctr - 1)];
          if (occ == 1) top_ctr = top_ctr + 1;
          else bot_ctr = bot_ctr - 1;
        end
      end
      ACT_POPTOP: begin
        if (occ == 0) begin
          r.status = ST_EMPTY;
          r.data   = fail_val;
          empty_cnt++;
        end else begin
          r.data  = slot_mem[slot_of(top_ctr)];
          top_ctr = top_ctr + 1;
        end
      end
      default: begin
        if (top_ctr != bot_ctr) begin
          r.status = ST_NOTEMPTY;
          reject_cnt++;
        end else begin
          top_ctr = b.depth_value;
          bot_ctr = b.depth_value;
        end
      end
    endcase
    result_due_q.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    err_cnt++;
    if (err_cnt <= 30)
      $display("[%0t] mismatch on result beat %0d, %s: got %h want %h",
               $time, res_cnt, what, got, want);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 48);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 64'hFFFF_FFFF_FFFF_FFFF;
      2:       return word_t'(1) << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic word_t rand_depth();
    case ($urandom_range(0, 5))
      0:       return 64'hFFFF_FFFF_FFFF_FFFF - word_t'($urandom_range(0, 80));
      1:       return word_t'($urandom_range(0, 200));
      default: return rand_word();
    endcase
  endfunction

  function automatic action_t rand_pop();
    return $urandom_range(0, 1) ? ACT_POPBOT : ACT_POPTOP;
  endfunction

  function automatic action_t rand_action();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return ACT_PUSH;
    if (r < 65) return ACT_POPBOT;
    if (r < 90) return ACT_POPTOP;
    return ACT_SETDEPTH;
  endfunction

  function automatic void add_beat(input action_t a, input word_t e, input word_t d);
    action_beat_t b;
    b.act         = a;
    b.element     = e;
    b.depth_value = d;
    pending_q.push_back(b);
    gen_cnt++;
  endfunction

  task automatic gen_phase(input int unsigned n);
    int unsigned stop_at;
    int unsigned r;
    stop_at = gen_cnt + n;
    while (gen_cnt < stop_at) begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        repeat ($urandom_range(40, 72))
          add_beat(($urandom_range(0, 9) == 0) ? rand_pop() : ACT_PUSH,
                   rand_word(), rand_word());
      end else if (r < 5) begin
        repeat ($urandom_range(8, 70)) add_beat(rand_pop(), rand_word(), rand_word());
      end else if (r < 8) begin
        repeat ($urandom_range(4, 30)) add_beat(rand_action(), rand_word(), rand_depth());
      end else if (r == 8) begin
        repeat ($urandom_range(0, 4)) add_beat(rand_pop(), rand_word(), rand_word());
        add_beat(ACT_SETDEPTH, rand_word(), rand_depth());
        repeat ($urandom_range(1, 8)) add_beat(ACT_PUSH, rand_word(), rand_word());
      end else begin
        repeat ($urandom_range(1, 6))
          add_beat(action_t'($urandom_range(0, 3)), rand_word(), rand_word());
      end
    end
  endtask

  task automatic write_fail(input word_t v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_cnt++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || taken_cnt != issued_cnt || result_due_q.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // accept side: configuration and action beats feed the predictor
  always @(posedge clk) begin
    action_beat_t b;
    if (!rst_n) begin
      top_ctr  = '0;
      bot_ctr  = '0;
      fail_val = '0;
    end else begin
      if (cfg_we) fail_val = cfg_wdata;
      if (in_if.valid && in_if.ready) begin
        b.act         = in_if.action;
        b.element     = in_if.element;
        b.depth_value = in_if.depth_value;
        deque_step(b);
        taken_cnt++;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    action_beat_t b;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (taken_cnt == issued_cnt) begin
      if (in_gap != 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        b = pending_q.pop_front();
        in_if.valid       <= 1'b1;
        in_if.action      <= b.act;
        in_if.element     <= b.element;
        in_if.depth_value <= b.depth_value;
        issued_cnt++;
        in_gap = pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (out_stall != 0) begin
      out_stall--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_stall = pick_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (result_due_q.size() == 0) begin
        report_mismatch("beat with nothing due", out_if.data, '0);
      end else begin
        want = result_due_q.pop_front();
        if (out_if.status !== want.status)
          report_mismatch("status", word_t'(out_if.status), word_t'(want.status));
        if (out_if.data !== want.data)
          report_mismatch("data", out_if.data, want.data);
      end
      res_cnt++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due",
               cycle_cnt, result_due_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    word_t fail_plan [PHASES];
    in_if.valid       = 1'b0;
    in_if.action      = ACT_PUSH;
    in_if.element     = '0;
    in_if.depth_value = '0;
    out_if.ready      = 1'b0;
    fail_plan[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    fail_plan[1] = {$urandom, $urandom};
    fail_plan[2] = '0;
    fail_plan[3] = 64'h8000_0000_0000_0001;
    fail_plan[4] = {$urandom, $urandom};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_beat(ACT_POPBOT,   rand_word(), rand_word());
    add_beat(ACT_POPTOP,   rand_word(), rand_word());
    add_beat(ACT_SETDEPTH, rand_word(), '0);
    add_beat(ACT_SETDEPTH, rand_word(), 64'hFFFF_FFFF_FFFF_FFFE);
    add_beat(ACT_PUSH,     64'hFFFF_FFFF_FFFF_FFFF, '0);
    add_beat(ACT_PUSH,     '0, 64'hFFFF_FFFF_FFFF_FFFF);
    add_beat(ACT_PUSH,     64'h8000_0000_0000_0000, '0);
    add_beat(ACT_SETDEPTH, '0, 64'd5);
    add_beat(ACT_POPTOP,   rand_word(), rand_word());
    add_beat(ACT_POPBOT,   rand_word(), rand_word());
    add_beat(ACT_POPBOT,   rand_word(), rand_word());
    add_beat(ACT_POPBOT,   rand_word(), rand_word());
    add_beat(ACT_PUSH,     64'hA5A5_5A5A_0F0F_F0F0, rand_word());
    add_beat(ACT_POPTOP,   rand_word(), rand_word());
    add_beat(ACT_POPTOP,   rand_word(), rand_word());
    add_beat(ACT_SETDEPTH, rand_word(), 64'hFFFF_FFFF_FFFF_FFFF);
    add_beat(ACT_PUSH,     64'h0123_4567_89AB_CDEF, rand_word());
    add_beat(ACT_PUSH,     64'hFEDC_BA98_7654_3210, rand_word());
    add_beat(ACT_POPBOT,   rand_word(), rand_word());
    add_beat(ACT_POPBOT,   rand_word(), rand_word());
    add_beat(ACT_SETDEPTH, rand_word(), '0);
    add_beat(ACT_PUSH,     64'd1, rand_word());
    add_beat(ACT_POPBOT,   rand_word(), rand_word());
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      write_fail(fail_plan[p]);
      steady = (p == 2);
      if (p == 0) repeat (DEPTH + 4) add_beat(ACT_PUSH, rand_word(), rand_word());
      gen_phase(PHASE_BEATS);
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d actions (%0d push, %0d pop bottom, %0d steal, %0d set depth),",
             taken_cnt, act_cnt[ACT_PUSH], act_cnt[ACT_POPBOT], act_cnt[ACT_POPTOP],
             act_cnt[ACT_SETDEPTH]);
    $display("%0d fail words; hit %0d pushes when full, %0d pops when empty, %0d refused set depth; %0d errors",
             cfg_cnt, full_cnt, empty_cnt, reject_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
